// ===== rtl/aesctr_pkg.sv =====
package aesctr_pkg;

  localparam int unsigned MaxRequestDefault = 64;
  localparam int unsigned OutLimit          = 64;
  localparam int unsigned NumRounds         = 14;
  localparam int unsigned NumCfgRegs        = 6;
  localparam int unsigned CfgAddrWidth      = 6;

  // Configuration register indexes.
  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegIv0  = 3'd4;
  localparam logic [2:0] RegIv1  = 3'd5;

  typedef struct packed {
    logic       restart;
    logic [6:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic        last_chunk;
    logic [3:0]  chunk_bytes;
    logic [63:0] stream_chunk;
  } chunk_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic       restart;
    logic [6:0] len;
  } cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gf_mul = r;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    sbox_calc = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
              ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  // Constant S-box table, built at elaboration.
  function automatic logic [255:0][7:0] sbox_build();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    sbox_build = t;
  endfunction

  localparam logic [255:0][7:0] SBOX = sbox_build();

  localparam logic [9:0][7:0] RCON = {8'h36, 8'h1b, 8'h80, 8'h40, 8'h20,
                                       8'h10, 8'h08, 8'h04, 8'h02, 8'h01};

  // Byte i of a state lives in bits 8*i+7:8*i.
  function automatic logic [127:0] sub_bytes(input logic [127:0] s);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = SBOX[s[8*i +: 8]];
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[8*(r+4*c) +: 8] = s[8*(r+4*((c+r)%4)) +: 8];
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[8*(4*c)   +: 8];
      a1 = s[8*(4*c+1) +: 8];
      a2 = s[8*(4*c+2) +: 8];
      a3 = s[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = o;
  endfunction

  // Word transform for key expansion: optional rotate, S-box, round constant.
  function automatic logic [31:0] key_word_fn(input logic [31:0] w, input logic rot,
                                              input logic [7:0] rc);
    logic [31:0] t;
    t = rot ? {w[7:0], w[31:8]} : w;
    for (int j = 0; j < 4; j++) t[8*j +: 8] = SBOX[t[8*j +: 8]];
    t[7:0] = t[7:0] ^ rc;
    key_word_fn = t;
  endfunction

  // 128-bit big-endian increment on a byte-0-in-low-bits layout.
  function automatic logic [127:0] ctr_inc(input logic [127:0] c);
    logic [127:0] be;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) be[8*(15-i) +: 8] = c[8*i +: 8];
    be = be + 128'd1;
    for (int i = 0; i < 16; i++) o[8*i +: 8] = be[8*(15-i) +: 8];
    ctr_inc = o;
  endfunction

endpackage

// ===== rtl/aesctr_ram.sv =====
module aesctr_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/aesctr_front.sv =====
module aesctr_front #(
  parameter int unsigned MaxRequest = aesctr_pkg::MaxRequestDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aesctr_pkg::req_t   in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_stall_i,
  output aesctr_pkg::cmd_t   cmd_data_o
);

  localparam int unsigned Lim = (MaxRequest < aesctr_pkg::OutLimit) ?
                                MaxRequest : aesctr_pkg::OutLimit;
  localparam int unsigned QDepth = 2;

  logic                started_q;
  aesctr_pkg::cmd_t    fifo_q [QDepth];
  logic                wptr_q, rptr_q;
  logic [1:0]          cnt_q;
  logic                push, pop;
  aesctr_pkg::cmd_t    cls;

  // Classify: clamp length, force restart on the first transaction.
  always_comb begin
    cls.restart = in_data_i.restart | ~started_q;
    cls.len     = (in_data_i.request_bytes > 7'(Lim)) ? 7'(Lim) : in_data_i.request_bytes;
  end

  assign in_stall_o  = (cnt_q == 2'(QDepth));
  assign push        = in_valid_i & ~in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & ~cmd_stall_i;
  assign cmd_data_o  = fifo_q[rptr_q];

  // Two-entry queue toward the back part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      wptr_q    <= 1'b0;
      rptr_q    <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (push) begin
        started_q <= 1'b1;
        wptr_q    <= ~wptr_q;
      end
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= cls;
  end

endmodule

// ===== rtl/aesctr_back.sv =====
module aesctr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [255:0]       key_i,
  input  logic [127:0]       iv_i,
  input  logic               cmd_valid_i,
  output logic               cmd_stall_o,
  input  aesctr_pkg::cmd_t   cmd_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aesctr_pkg::chunk_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle, StKey, StLoad, StRound, StEmit
  } state_e;

  state_e         state_q;
  logic [6:0]     rem_q;        // bytes still to send for this transaction
  logic [127:0]   ctr_q;
  logic [127:0]   left_q;       // leftover bytes, next byte in low bits
  logic [4:0]     lcnt_q;       // 0..16 bytes in left_q
  logic [63:0]    acc_q;
  logic [3:0]     acnt_q;
  logic [127:0]   st_q;
  logic [3:0]     rnd_q;
  // key expansion
  logic [255:0]   kw_q;         // last eight words, newest in top bits
  logic [3:0]     kidx_q;       // round key being written
  logic [3:0]     kstep_q;      // word group step
  logic [3:0]     rcidx_q;
  logic           ram_we;
  logic [3:0]     ram_wa, ram_ra;
  logic [127:0]   ram_wd, rk;
  // output register
  logic           ov_q;
  aesctr_pkg::chunk_t od_q;
  logic [127:0]   lkw;
  logic [31:0]    nw0, nw1, nw2, nw3;
  logic           half;
  logic           chunk_go;

  aesctr_ram #(.Width(128), .Depth(15)) u_rk (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(rk)
  );

  // Round keys: 0,1 from the key; then 4 words per cycle, alternating form.
  assign half = kstep_q[0];
  always_comb begin
    nw0 = kw_q[31:0] ^ aesctr_pkg::key_word_fn(kw_q[255:224], ~half,
                                               half ? 8'h00 : aesctr_pkg::RCON[rcidx_q]);
    nw1 = kw_q[63:32] ^ nw0;
    nw2 = kw_q[95:64] ^ nw1;
    nw3 = kw_q[127:96] ^ nw2;
    lkw = {nw3, nw2, nw1, nw0};
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = kidx_q;
    ram_wd = lkw;
    if (state_q == StKey) begin
      ram_we = 1'b1;
      if (kidx_q == 4'd0) ram_wd = kw_q[127:0];
      else if (kidx_q == 4'd1) ram_wd = kw_q[255:128];
    end
  end

  // Round key read in the cycle before its use; round key 0 is held while
  // waiting for the next block load.
  assign ram_ra = (state_q == StLoad) ? 4'd1 :
                  (state_q == StRound && rnd_q != 4'(aesctr_pkg::NumRounds)) ?
                  rnd_q + 4'd1 : 4'd0;

  // A chunk goes out when it is full or the transaction is done and the
  // output register is free.
  assign chunk_go = (state_q == StEmit) && (acnt_q == 4'd8 || rem_q == 7'd0) &&
                    (!ov_q || !out_stall_i);

  assign cmd_stall_o = (state_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      lcnt_q  <= 5'd0;
      ctr_q   <= '0;
      rem_q   <= '0;
      acnt_q  <= '0;
      kidx_q  <= '0;
      kstep_q <= '0;
      rcidx_q <= '0;
      rnd_q   <= '0;
    end else begin
      if (chunk_go) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            rem_q  <= cmd_data_i.len;
            acnt_q <= 4'd0;
            acc_q  <= '0;
            if (cmd_data_i.restart) begin
              ctr_q   <= iv_i;
              lcnt_q  <= 5'd0;
              kw_q    <= key_i;
              kidx_q  <= 4'd0;
              kstep_q <= 4'd0;
              rcidx_q <= 4'd0;
              state_q <= StKey;
            end else if (cmd_data_i.len != 7'd0) begin
              state_q <= StEmit;
            end
          end
        end
        StKey: begin
          kidx_q <= kidx_q + 4'd1;
          if (kidx_q >= 4'd2) begin
            kw_q    <= {lkw, kw_q[255:128]};
            kstep_q <= kstep_q + 4'd1;
            if (!half) rcidx_q <= rcidx_q + 4'd1;
          end
          if (kidx_q == 4'd14) state_q <= (rem_q != 7'd0) ? StEmit : StIdle;
        end
        StLoad: begin
          st_q    <= ctr_q ^ rk;
          rnd_q   <= 4'd1;
          state_q <= StRound;
        end
        StRound: begin
          if (rnd_q == 4'(aesctr_pkg::NumRounds)) begin
            left_q  <= aesctr_pkg::shift_rows(aesctr_pkg::sub_bytes(st_q)) ^ rk;
            lcnt_q  <= 5'd16;
            ctr_q   <= aesctr_pkg::ctr_inc(ctr_q);
            state_q <= StEmit;
          end else begin
            st_q  <= aesctr_pkg::mix_columns(
                       aesctr_pkg::shift_rows(aesctr_pkg::sub_bytes(st_q))) ^ rk;
            rnd_q <= rnd_q + 4'd1;
          end
        end
        StEmit: begin
          // One byte per cycle into the chunk while leftover bytes remain; send when full or done.
          if (ov_q && !out_stall_i || !ov_q || (acnt_q != 4'd8 && rem_q != 7'd0)) begin
            if (acnt_q == 4'd8 || rem_q == 7'd0) begin
              od_q.stream_chunk      <= acc_q;
              od_q.chunk_bytes       <= acnt_q;
              od_q.last_chunk        <= (rem_q == 7'd0);
              acc_q                  <= '0;
              acnt_q                 <= 4'd0;
              if (rem_q == 7'd0) state_q <= StIdle;
            end else if (lcnt_q == 5'd0) begin
              state_q <= StLoad;
            end else begin
              acc_q[8*acnt_q[2:0] +: 8] <= left_q[7:0];
              left_q <= {8'h00, left_q[127:8]};
              lcnt_q <= lcnt_q - 5'd1;
              acnt_q <= acnt_q + 4'd1;
              rem_q  <= rem_q - 7'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/aes256_ctr_keystream.sv =====
// A restart first runs key expansion; each new block then passes through the
// single iterated round unit; bytes are packed one per cycle while leftover bytes remain.
// Transaction time is set by the round unit, the byte packer and the chunk sends;
// a new block is not started until the leftover bytes of the last one are used up.
// Reset clears the control state, counter and leftover count; configuration
// registers reset to zero and round keys are written on the first transaction.
module aes256_ctr_keystream #(
  parameter int unsigned MaxRequest = aesctr_pkg::MaxRequestDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  aesctr_pkg::req_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aesctr_pkg::chunk_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [aesctr_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [5:0][63:0] cfg_q;
  logic             cmd_valid, cmd_stall;
  aesctr_pkg::cmd_t cmd_data;
  logic [2:0]       ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0 &&
                 ridx < 3'(aesctr_pkg::NumCfgRegs)) begin
      cfg_q[ridx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx < 3'(aesctr_pkg::NumCfgRegs)) prdata = cfg_q[ridx];
  end

  aesctr_front #(.MaxRequest(MaxRequest)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_stall_i(cmd_stall), .cmd_data_o(cmd_data)
  );

  aesctr_back u_back (
    .clk_i, .rst_ni,
    .key_i({cfg_q[aesctr_pkg::RegKey3], cfg_q[aesctr_pkg::RegKey2],
            cfg_q[aesctr_pkg::RegKey1], cfg_q[aesctr_pkg::RegKey0]}),
    .iv_i({cfg_q[aesctr_pkg::RegIv1], cfg_q[aesctr_pkg::RegIv0]}),
    .cmd_valid_i(cmd_valid), .cmd_stall_o(cmd_stall), .cmd_data_i(cmd_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== rtl/aesctr_checker.sv =====
module aesctr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input aesctr_pkg::chunk_t out_data_o,
  input logic               pready
);

  // A chunk always carries between one and eight bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.chunk_bytes != 4'd0 && out_data_o.chunk_bytes <= 4'd8)
    else $error("bad chunk size");

  // Only the last chunk may be short.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chunk_bytes != 4'd8 |-> out_data_o.last_chunk)
    else $error("short chunk not last");

  // A stalled chunk holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled chunk changed");

  assert property (@(posedge clk_i) pready) else $error("pready low");

endmodule

bind aes256_ctr_keystream aesctr_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o, .pready
);
